@@ sv/slcs_pkg.sv @@
`timescale 1ns / 1ps
// slcs_pkg: shared constants, types and helper functions for the lattice step unit.
// Depends on nothing; used by every other file of the unit but slcs_ram.
package slcs_pkg;

  // Lattice geometry
  localparam int MAX_SIDE = 64;
  localparam int IDX_W    = $clog2(MAX_SIDE);
  localparam int N_W      = IDX_W + 1;
  localparam int CELLS    = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W   = $clog2(CELLS);

  // Field widths fixed by the interface
  localparam int SIDE_W  = 7;
  localparam int FRAC_W  = 16;
  localparam int RED_W   = 13;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int CMP_W   = (N_W > SIDE_W) ? N_W : SIDE_W;

  // Weights: 1.0 in Q1.16 and running sums of three of them
  localparam int WGT_W = FRAC_W + 1;
  localparam int SUM_W = WGT_W + 1;
  localparam logic [WGT_W-1:0] Q16_ONE = WGT_W'(65536);

  localparam logic [RED_W-1:0]  TALLY_MAX  = {RED_W{1'b1}};
  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(64);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(MAX_SIDE);

  // Codes
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;
  localparam logic STRAIN_R   = 1'b0;
  localparam logic STRAIN_B   = 1'b1;
  localparam logic BANK_A     = 1'b0;
  localparam logic BANK_B     = 1'b1;

  localparam logic [1:0] REG_SIDE      = 2'd0;
  localparam logic [1:0] REG_SELECTION = 2'd1;
  localparam logic [1:0] REG_MUTATION  = 2'd2;

  typedef enum logic [1:0] {
    STEP_SELF,
    STEP_NB1,
    STEP_NB2
  } slcs_step_e;

  typedef struct packed {
    logic [SIDE_W-1:0] side;
    logic [FRAC_W-1:0] selection;
    logic [FRAC_W-1:0] mutation;
  } slcs_cfg_t;

  typedef struct packed {
    logic              en;
    logic              bank;
    logic [ADDR_W-1:0] addr;
  } slcs_rd_t;

  typedef struct packed {
    logic              en;
    logic              bank;
    logic [ADDR_W-1:0] addr;
    logic              data;
  } slcs_wr_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic              dst;
    logic [ADDR_W-1:0] addr;
    logic [FRAC_W-1:0] pick;
    logic [FRAC_W-1:0] mut;
  } slcs_job_t;

  typedef struct packed {
    logic take0;
    logic take1;
  } slcs_cap_t;

  typedef struct packed {
    logic stall;
    logic hold_last;
  } slcs_evs_t;

  // Side in use, saturated to 2..MAX_SIDE
  function automatic logic [N_W-1:0] eff_side(input logic [SIDE_W-1:0] s);
    logic [CMP_W-1:0] sx;
    sx = CMP_W'(s);
    if (sx < CMP_W'(2)) begin
      return N_W'(2);
    end else if (sx > CMP_W'(MAX_SIDE)) begin
      return N_W'(MAX_SIDE);
    end else begin
      return N_W'(sx);
    end
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ROW_STRIDE) + ADDR_W'(c);
  endfunction

endpackage

@@ sv/slcs_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// slcs_ram: generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module slcs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while re_i is low
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ sv/slcs_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// slcs_cfg: APB-style register file (side, selection, mutation rate).
// Depends on slcs_pkg.
module slcs_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [slcs_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [slcs_pkg::PDATA_W-1:0]    pwdata,
  output logic      [slcs_pkg::PDATA_W-1:0]    prdata,
  output logic                                 pready,
  output slcs_pkg::slcs_cfg_t                  cfg_o
);

  logic [slcs_pkg::SIDE_W-1:0] side_q;
  logic [slcs_pkg::FRAC_W-1:0] sel_q;
  logic [slcs_pkg::FRAC_W-1:0] mut_q;
  logic                        wr_en;
  logic [1:0]                  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= slcs_pkg::SIDE_RESET;
      sel_q  <= '0;
      mut_q  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        slcs_pkg::REG_SIDE:      side_q <= pwdata[slcs_pkg::SIDE_W-1:0];
        slcs_pkg::REG_SELECTION: sel_q  <= pwdata[slcs_pkg::FRAC_W-1:0];
        slcs_pkg::REG_MUTATION:  mut_q  <= pwdata[slcs_pkg::FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      slcs_pkg::REG_SIDE:      prdata = slcs_pkg::PDATA_W'(side_q);
      slcs_pkg::REG_SELECTION: prdata = slcs_pkg::PDATA_W'(sel_q);
      slcs_pkg::REG_MUTATION:  prdata = slcs_pkg::PDATA_W'(mut_q);
      default:                 prdata = '0;
    endcase
  end

  assign cfg_o.side      = side_q;
  assign cfg_o.selection = sel_q;
  assign cfg_o.mutation  = mut_q;

endmodule
`default_nettype wire

@@ sv/slcs_issue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// slcs_issue: input stage, scan cursor and read sequencer for the lattice banks.
// Depends on slcs_pkg.
module slcs_issue (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          action_i,
  input  wire logic                          load_strain_i,
  input  wire logic [slcs_pkg::FRAC_W-1:0]   rand_pick_i,
  input  wire logic [slcs_pkg::FRAC_W-1:0]   rand_mutate_i,
  input  wire logic [slcs_pkg::SIDE_W-1:0]   side_i,
  input  slcs_pkg::slcs_evs_t                evs_i,
  output slcs_pkg::slcs_rd_t                 rd_o,
  output slcs_pkg::slcs_wr_t                 ld_o,
  output slcs_pkg::slcs_cap_t                cap_o,
  output slcs_pkg::slcs_job_t                job_o
);

  localparam int IW = slcs_pkg::IDX_W;

  slcs_pkg::slcs_step_e step_q, step_d;
  logic                 iss_valid_q, iss_valid_d;
  logic [IW-1:0]        row_q, row_d, col_q, col_d;
  logic                 phase_q, phase_d;

  logic                        act_q, strain_q;
  logic [slcs_pkg::FRAC_W-1:0] pick_q, mut_q;

  logic [slcs_pkg::N_W-1:0] n, nm1_w;
  logic [IW-1:0]            nm1, r, c, r1, rm, c1, cm;
  logic [IW-1:0]            nb_r, nb_c;
  logic                     is_upd, go, done, accept, last;

  always_comb begin
    n     = slcs_pkg::eff_side(side_i);
    nm1_w = n - slcs_pkg::N_W'(1);
    nm1   = nm1_w[IW-1:0];
    // cursor beyond the side in use is pulled back to the edge
    r  = (slcs_pkg::N_W'(row_q) >= n) ? nm1 : row_q;
    c  = (slcs_pkg::N_W'(col_q) >= n) ? nm1 : col_q;
    r1 = (r == nm1) ? '0 : r + IW'(1);
    rm = (r == '0) ? nm1 : r - IW'(1);
    c1 = (c == nm1) ? '0 : c + IW'(1);
    cm = (c == '0) ? nm1 : c - IW'(1);
    last = (r == nm1) && (c == nm1);
  end

  assign is_upd     = (act_q == slcs_pkg::ACT_UPDATE);
  assign go         = iss_valid_q && !evs_i.stall && !evs_i.hold_last;
  assign done       = go && (!is_upd || (step_q == slcs_pkg::STEP_NB2));
  assign in_ready_o = !iss_valid_q || done;
  assign accept     = in_valid_i && in_ready_o;

  // neighbour coordinates per sweep parity and column parity
  always_comb begin
    nb_r = r;
    nb_c = c;
    case (step_q)
      slcs_pkg::STEP_SELF: begin
        nb_r = r;
        nb_c = c;
      end
      slcs_pkg::STEP_NB1: begin
        if (!phase_q) begin
          nb_r = c[0] ? rm : r;
          nb_c = c1;
        end else begin
          nb_r = r;
          nb_c = cm;
        end
      end
      slcs_pkg::STEP_NB2: begin
        if (!phase_q) begin
          nb_r = c[0] ? r : r1;
          nb_c = c1;
        end else begin
          nb_r = c[0] ? rm : r1;
          nb_c = cm;
        end
      end
      default: begin
        nb_r = r;
        nb_c = c;
      end
    endcase
  end

  // source bank follows the sweep phase; updates write the other one
  assign rd_o.en   = go && is_upd;
  assign rd_o.bank = phase_q;
  assign rd_o.addr = slcs_pkg::cell_addr(nb_r, nb_c);

  assign ld_o.en   = go && !is_upd;
  assign ld_o.bank = phase_q;
  assign ld_o.addr = slcs_pkg::cell_addr(r, c);
  assign ld_o.data = strain_q;

  // read data holds while stalled, so capture needs no handshake
  assign cap_o.take0 = iss_valid_q && is_upd && (step_q == slcs_pkg::STEP_NB1);
  assign cap_o.take1 = iss_valid_q && is_upd && (step_q == slcs_pkg::STEP_NB2);

  assign job_o.valid = done && is_upd;
  assign job_o.last  = last;
  assign job_o.dst   = !phase_q;
  assign job_o.addr  = slcs_pkg::cell_addr(r, c);
  assign job_o.pick  = pick_q;
  assign job_o.mut   = mut_q;

  always_comb begin
    step_d      = step_q;
    iss_valid_d = iss_valid_q;
    row_d       = row_q;
    col_d       = col_q;
    phase_d     = phase_q;
    if (go && is_upd) begin
      case (step_q)
        slcs_pkg::STEP_SELF: step_d = slcs_pkg::STEP_NB1;
        slcs_pkg::STEP_NB1:  step_d = slcs_pkg::STEP_NB2;
        slcs_pkg::STEP_NB2:  step_d = slcs_pkg::STEP_SELF;
        default:             step_d = slcs_pkg::STEP_SELF;
      endcase
    end
    if (done) begin
      iss_valid_d = 1'b0;
      if (is_upd && last) begin
        row_d   = '0;
        col_d   = '0;
        phase_d = !phase_q;
      end else begin
        col_d = c1;
        row_d = (c == nm1) ? r1 : r;
      end
    end
    if (accept) begin
      iss_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= slcs_pkg::STEP_SELF;
      iss_valid_q <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      phase_q     <= 1'b0;
    end else begin
      step_q      <= step_d;
      iss_valid_q <= iss_valid_d;
      row_q       <= row_d;
      col_q       <= col_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q    <= action_i;
      strain_q <= load_strain_i;
      pick_q   <= rand_pick_i;
      mut_q    <= rand_mutate_i;
    end
  end

endmodule
`default_nettype wire

@@ sv/slcs_eval.sv @@
`timescale 1ns / 1ps
`default_nettype none
// slcs_eval: winner choice, mutation, red tally and the result register.
// Depends on slcs_pkg.
module slcs_eval (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  slcs_pkg::slcs_job_t                job_i,
  input  slcs_pkg::slcs_cap_t                cap_i,
  input  wire logic                          rdata_i,
  input  wire logic [slcs_pkg::FRAC_W-1:0]   selection_i,
  input  wire logic [slcs_pkg::FRAC_W-1:0]   mutation_i,
  output slcs_pkg::slcs_wr_t                 wr_o,
  output slcs_pkg::slcs_evs_t                evs_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               new_strain_o,
  output logic [slcs_pkg::RED_W-1:0]         red_count_o,
  output logic                               sweep_last_o,
  output logic                               extinct_o
);

  localparam int WW = slcs_pkg::WGT_W;
  localparam int SW = slcs_pkg::SUM_W;
  localparam int PW = SW + slcs_pkg::FRAC_W;

  logic                      ev_valid_q, ev_valid_d;
  slcs_pkg::slcs_job_t       ev_q;
  logic                      cand0_q, cand1_q;
  logic [slcs_pkg::RED_W-1:0] tally_q, tally_d;
  logic                      out_valid_q, out_valid_d;
  logic                      ns_q, last_q, ext_q;
  logic [slcs_pkg::RED_W-1:0] red_q;

  logic                      stall, fire, cand2, win, mutate, ns;
  logic [WW-1:0]             w_b, w0, w1, w2;
  logic [SW-1:0]             run0, run1, total;
  logic [PW-1:0]             thresh, lhs0, lhs1;
  logic [slcs_pkg::RED_W-1:0] tally_new;

  assign stall = ev_valid_q && out_valid_q && !out_ready_i;
  assign fire  = ev_valid_q && !stall;
  assign cand2 = rdata_i;

  // weight 1.0 for R, 1.0 - selection for B
  always_comb begin
    w_b    = slcs_pkg::Q16_ONE - WW'(selection_i);
    w0     = (cand0_q == slcs_pkg::STRAIN_B) ? w_b : slcs_pkg::Q16_ONE;
    w1     = (cand1_q == slcs_pkg::STRAIN_B) ? w_b : slcs_pkg::Q16_ONE;
    w2     = (cand2 == slcs_pkg::STRAIN_B) ? w_b : slcs_pkg::Q16_ONE;
    run0   = SW'(w0);
    run1   = SW'(w0) + SW'(w1);
    total  = run1 + SW'(w2);
    thresh = PW'(ev_q.pick) * PW'(total);
    lhs0   = {run0, {slcs_pkg::FRAC_W{1'b0}}};
    lhs1   = {run1, {slcs_pkg::FRAC_W{1'b0}}};
    if (lhs0 > thresh) begin
      win = cand0_q;
    end else if (lhs1 > thresh) begin
      win = cand1_q;
    end else begin
      win = cand2;
    end
    mutate    = (mutation_i != '0) && (ev_q.mut < mutation_i);
    ns        = win | mutate;
    tally_new = ((ns == slcs_pkg::STRAIN_R) && (tally_q != slcs_pkg::TALLY_MAX)) ?
                tally_q + slcs_pkg::RED_W'(1) : tally_q;
  end

  always_comb begin
    ev_valid_d  = ev_valid_q;
    tally_d     = tally_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (fire) begin
      ev_valid_d  = 1'b0;
      out_valid_d = 1'b1;
      tally_d     = ev_q.last ? '0 : tally_new;
    end
    if (job_i.valid) begin
      ev_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q  <= 1'b0;
      tally_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ev_valid_q  <= ev_valid_d;
      tally_q     <= tally_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_i.valid) begin
      ev_q <= job_i;
    end
    if (cap_i.take0) begin
      cand0_q <= rdata_i;
    end
    if (cap_i.take1) begin
      cand1_q <= rdata_i;
    end
    if (fire) begin
      ns_q   <= ns;
      red_q  <= tally_new;
      last_q <= ev_q.last;
      ext_q  <= ev_q.last && (tally_new == '0);
    end
  end

  assign wr_o.en   = fire;
  assign wr_o.bank = ev_q.dst;
  assign wr_o.addr = ev_q.addr;
  assign wr_o.data = ns;

  assign evs_o.stall     = stall;
  assign evs_o.hold_last = ev_valid_q && ev_q.last;

  assign out_valid_o  = out_valid_q;
  assign new_strain_o = ns_q;
  assign red_count_o  = red_q;
  assign sweep_last_o = last_q;
  assign extinct_o    = ext_q;

endmodule
`default_nettype wire

@@ sv/stochastic_lattice_competition_step_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// stochastic_lattice_competition_step_unit: top level, two lattice banks plus sequencer.
// Depends on slcs_pkg, slcs_ram, slcs_cfg, slcs_issue, slcs_eval.
//
//  Channel   Dir  Handshake               Payload
//  in        in   in_valid_i/in_ready_o   action_i, load_strain_i, rand_pick_i, rand_mutate_i
//  out       out  out_valid_o/out_ready_i new_strain_o, red_count_o, sweep_last_o, extinct_o
//  cfg       in   psel/penable/pwrite     paddr, pwdata, prdata (pready tied high)
//
// Update transaction: one issue step per read of the single read port of the source bank
// (cell, then two neighbours); a new update follows back to back unless the issue stage is held.
// Load transaction: written straight into the source bank.
// A sweep's final update holds the issue stage: the next transaction waits until its
// write has landed in the bank that becomes the source.
// A result passes the issue, evaluate and result registers; the result register frees the input side.
// Reset clears cursor, phase, tally, flags and config; lattice contents are undefined until loaded.
// A stalled result register holds the evaluate stage and, behind it, the issue stage.
module stochastic_lattice_competition_step_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // item input
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          action_i,
  input  wire logic                          load_strain_i,
  input  wire logic [slcs_pkg::FRAC_W-1:0]   rand_pick_i,
  input  wire logic [slcs_pkg::FRAC_W-1:0]   rand_mutate_i,
  // result output
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               new_strain_o,
  output logic [slcs_pkg::RED_W-1:0]         red_count_o,
  output logic                               sweep_last_o,
  output logic                               extinct_o,
  // register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [slcs_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [slcs_pkg::PDATA_W-1:0]  pwdata,
  output logic      [slcs_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);

  slcs_pkg::slcs_cfg_t cfg;
  slcs_pkg::slcs_evs_t evs;
  slcs_pkg::slcs_rd_t  rd;
  slcs_pkg::slcs_wr_t  ld;
  slcs_pkg::slcs_wr_t  wr;
  slcs_pkg::slcs_cap_t cap;
  slcs_pkg::slcs_job_t job;

  // which bank the last read went to; holds with the RAM read data
  logic rd_bank_q;
  logic rdata;

  // per-bank port muxing: loads hit the source bank, updates the destination
  logic                        we_a, we_b, ld_a, ld_b, re_a, re_b;
  logic                        wd_a, wd_b;
  logic [slcs_pkg::ADDR_W-1:0] wa_a, wa_b;
  logic [0:0]                  rdata_a, rdata_b;

  slcs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  slcs_issue u_issue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .load_strain_i (load_strain_i),
    .rand_pick_i   (rand_pick_i),
    .rand_mutate_i (rand_mutate_i),
    .side_i        (cfg.side),
    .evs_i         (evs),
    .rd_o          (rd),
    .ld_o          (ld),
    .cap_o         (cap),
    .job_o         (job)
  );

  slcs_eval u_eval (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (job),
    .cap_i        (cap),
    .rdata_i      (rdata),
    .selection_i  (cfg.selection),
    .mutation_i   (cfg.mutation),
    .wr_o         (wr),
    .evs_o        (evs),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .new_strain_o (new_strain_o),
    .red_count_o  (red_count_o),
    .sweep_last_o (sweep_last_o),
    .extinct_o    (extinct_o)
  );

  always_comb begin
    ld_a = ld.en && (ld.bank == slcs_pkg::BANK_A);
    ld_b = ld.en && (ld.bank == slcs_pkg::BANK_B);
    we_a = ld_a || (wr.en && (wr.bank == slcs_pkg::BANK_A));
    we_b = ld_b || (wr.en && (wr.bank == slcs_pkg::BANK_B));
    wa_a = ld_a ? ld.addr : wr.addr;
    wa_b = ld_b ? ld.addr : wr.addr;
    wd_a = ld_a ? ld.data : wr.data;
    wd_b = ld_b ? ld.data : wr.data;
    re_a = rd.en && (rd.bank == slcs_pkg::BANK_A);
    re_b = rd.en && (rd.bank == slcs_pkg::BANK_B);
  end

  slcs_ram #(
    .WIDTH (1),
    .DEPTH (slcs_pkg::CELLS)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (wa_a),
    .wdata_i (wd_a),
    .re_i    (re_a),
    .raddr_i (rd.addr),
    .rdata_o (rdata_a)
  );

  slcs_ram #(
    .WIDTH (1),
    .DEPTH (slcs_pkg::CELLS)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (wa_b),
    .wdata_i (wd_b),
    .re_i    (re_b),
    .raddr_i (rd.addr),
    .rdata_o (rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_bank_q <= slcs_pkg::BANK_A;
    end else if (rd.en) begin
      rd_bank_q <= rd.bank;
    end
  end

  assign rdata = (rd_bank_q == slcs_pkg::BANK_B) ? rdata_b[0] : rdata_a[0];

`ifndef SYNTHESIS
  // a load and an update write never meet in the same bank
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ld.en && wr.en && (ld.bank == wr.bank)))
    else $error("two writers on one lattice bank");

  // nothing reads the banks while a sweep's final write is still pending
  a_sweep_interlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((rd.en || ld.en) && evs.hold_last))
    else $error("bank access before sweep-end write");

  // a finished read sequence only moves on when the evaluate stage is free
  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job.valid |-> !evs.stall)
    else $error("update handed to a stalled evaluate stage");

  // an update entering evaluate passes the evaluate register and then the result register
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job.valid && (!out_valid_o || out_ready_i) |=> ##1 out_valid_o)
    else $error("update produced no result");
`endif

endmodule
`default_nettype wire
